@@ sv/sdx_pkg.sv @@
// Shared types, constants and the letter-to-digit map for the Soundex encoder.
// No dependencies; used by sdx_word and soundex_text_encoder.
package sdx_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int DIGITS      = CODE_LENGTH - 1;
  localparam int MAX_RES     = CODE_LENGTH + 1;
  localparam int DCNT_W      = $clog2(CODE_LENGTH);
  localparam int RCNT_W      = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_W  = 8'h57;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic [7:0] text_char;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       char_valid;
    logic       output_end;
  } out_t;

  // results caused by one request; entry 0 goes out first
  typedef struct packed {
    logic [RCNT_W-1:0]       count;
    out_t [MAX_RES-1:0]      res;
  } burst_t;

  // Soundex digit of an uppercase letter, 0 for vowels, Y, H and W
  function automatic logic [2:0] letter_digit(input logic [7:0] u);
    logic [2:0] d;
    d = 3'd0;
    case (u)
      8'h42, 8'h46, 8'h50, 8'h56:                         d = 3'd1; // B F P V
      8'h43, 8'h47, 8'h4A, 8'h4B, 8'h51, 8'h53, 8'h58, 8'h5A: d = 3'd2;
      8'h44, 8'h54:                                       d = 3'd3; // D T
      8'h4C:                                              d = 3'd4; // L
      8'h4D, 8'h4E:                                       d = 3'd5; // M N
      8'h52:                                              d = 3'd6; // R
      default:                                            d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/sdx_word.sv @@
// Per-word Soundex state and the result burst a text byte causes.
// Depends on sdx_pkg.
module sdx_word (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  sdx_pkg::in_t    item,
  output sdx_pkg::burst_t burst
);

  logic                        in_word_r, in_word_nxt;
  logic [7:0]                  first_r, first_nxt;
  logic [2:0]                  prev_r, prev_nxt;
  logic [sdx_pkg::DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [2:0]                  kept_r   [sdx_pkg::DIGITS];
  logic [2:0]                  kept_nxt [sdx_pkg::DIGITS];
  logic                        emitted_r, emitted_nxt;

  logic                        letter;
  logic [7:0]                  u;
  logic [2:0]                  d;
  logic                        word_end;
  logic [7:0]                  wch [sdx_pkg::CODE_LENGTH];

  always_comb begin
    logic [7:0] c;
    c      = item.text_char;
    letter = 1'b0;
    u      = c;
    if (c >= sdx_pkg::CH_UP_A && c <= sdx_pkg::CH_UP_Z) begin
      letter = 1'b1;
    end else if (c >= sdx_pkg::CH_LO_A && c <= sdx_pkg::CH_LO_Z) begin
      letter = 1'b1;
      u      = c - sdx_pkg::CASE_GAP;
    end
    d = sdx_pkg::letter_digit(u);
  end

  // word state after this byte's letter, before any word end
  always_comb begin
    logic                       iw;
    logic [7:0]                 fl;
    logic [2:0]                 pd;
    logic [sdx_pkg::DCNT_W-1:0] dc;
    logic [2:0]                 kd [sdx_pkg::DIGITS];
    iw = in_word_r;
    fl = first_r;
    pd = prev_r;
    dc = dcnt_r;
    kd = kept_r;
    if (letter) begin
      if (!in_word_r) begin
        iw = 1'b1;
        fl = u;
        pd = d;
        dc = '0;
      end else if (u == sdx_pkg::CH_UP_H || u == sdx_pkg::CH_UP_W) begin
        pd = prev_r;
      end else if (d == 3'd0) begin
        pd = 3'd0;
      end else if (d != prev_r) begin
        if (dcnt_r < sdx_pkg::DCNT_W'(sdx_pkg::DIGITS)) begin
          for (int i = 0; i < sdx_pkg::DIGITS; i++) begin
            if (dcnt_r == sdx_pkg::DCNT_W'(i)) kd[i] = d;
          end
          dc = dcnt_r + 1'b1;
        end
        pd = d;
      end
    end

    word_end = (item.text_char == sdx_pkg::CH_SPACE || item.text_end) && iw;

    // the finished word's characters
    wch[0] = fl;
    for (int i = 1; i < sdx_pkg::CODE_LENGTH; i++) begin
      if (dc >= sdx_pkg::DCNT_W'(i)) wch[i] = sdx_pkg::CH_ZERO | {5'd0, kd[i-1]};
      else                           wch[i] = sdx_pkg::CH_ZERO;
    end

    in_word_nxt = iw;
    first_nxt   = fl;
    prev_nxt    = pd;
    dcnt_nxt    = dc;
    kept_nxt    = kd;
    emitted_nxt = emitted_r;
    if (word_end) begin
      in_word_nxt = 1'b0;
      first_nxt   = '0;
      prev_nxt    = '0;
      dcnt_nxt    = '0;
      for (int i = 0; i < sdx_pkg::DIGITS; i++) kept_nxt[i] = '0;
      emitted_nxt = 1'b1;
    end
    if (item.text_end) begin
      in_word_nxt = 1'b0;
      first_nxt   = '0;
      prev_nxt    = '0;
      dcnt_nxt    = '0;
      for (int i = 0; i < sdx_pkg::DIGITS; i++) kept_nxt[i] = '0;
      emitted_nxt = 1'b0;
    end
  end

  // burst assembly
  always_comb begin
    burst = '0;
    if (word_end) begin
      if (emitted_r) begin
        burst.res[0] = '{code_char: sdx_pkg::CH_SPACE, char_valid: 1'b1, output_end: 1'b0};
        for (int i = 0; i < sdx_pkg::CODE_LENGTH; i++) begin
          burst.res[i+1] = '{code_char: wch[i], char_valid: 1'b1, output_end: 1'b0};
        end
        burst.count = sdx_pkg::RCNT_W'(sdx_pkg::CODE_LENGTH + 1);
      end else begin
        for (int i = 0; i < sdx_pkg::CODE_LENGTH; i++) begin
          burst.res[i] = '{code_char: wch[i], char_valid: 1'b1, output_end: 1'b0};
        end
        burst.count = sdx_pkg::RCNT_W'(sdx_pkg::CODE_LENGTH);
      end
      if (item.text_end) begin
        if (emitted_r) burst.res[sdx_pkg::CODE_LENGTH].output_end = 1'b1;
        else           burst.res[sdx_pkg::CODE_LENGTH-1].output_end = 1'b1;
      end
    end else if (item.text_end) begin
      // bare end marker
      burst.res[0] = '{code_char: 8'd0, char_valid: 1'b0, output_end: 1'b1};
      burst.count  = sdx_pkg::RCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= 1'b0;
      first_r   <= '0;
      prev_r    <= '0;
      dcnt_r    <= '0;
      emitted_r <= 1'b0;
      for (int i = 0; i < sdx_pkg::DIGITS; i++) kept_r[i] <= '0;
    end else if (step) begin
      in_word_r <= in_word_nxt;
      first_r   <= first_nxt;
      prev_r    <= prev_nxt;
      dcnt_r    <= dcnt_nxt;
      emitted_r <= emitted_nxt;
      kept_r    <= kept_nxt;
    end
  end

endmodule

@@ sv/soundex_text_encoder.sv @@
// Top level of the Soundex text encoder: word state plus an output shift buffer.
// Depends on sdx_pkg and sdx_word.
//
//   channel | direction | payload          | handshake
//   in_     | input     | sdx_pkg::in_t    | in_valid / in_ready
//   out_    | output    | sdx_pkg::out_t   | out_valid / out_ready
//
// Bytes that end no word are taken back to back while the buffer is empty.
// A word end loads up to CODE_LENGTH+1 results into the shift buffer; they leave
// one per cycle as out_ready allows; input stalls until the last is being taken.
// Synchronous active-low reset clears word state and empties the buffer.
module soundex_text_encoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdx_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sdx_pkg::out_t out_data
);

  sdx_pkg::burst_t              burst;
  sdx_pkg::out_t                buf_r   [sdx_pkg::MAX_RES];
  sdx_pkg::out_t                buf_nxt [sdx_pkg::MAX_RES];
  logic [sdx_pkg::RCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         in_take, out_take;

  assign out_valid = (cnt_r != '0);
  assign out_take  = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || (cnt_r == sdx_pkg::RCNT_W'(1) && out_ready);
  assign in_take   = in_valid && in_ready;
  assign out_data  = buf_r[0];

  sdx_word u_word (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_take),
    .item  (in_data),
    .burst (burst)
  );

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_take) begin
      // buffer is empty or drains this cycle
      for (int i = 0; i < sdx_pkg::MAX_RES; i++) buf_nxt[i] = burst.res[i];
      cnt_nxt = burst.count;
    end else if (out_take) begin
      for (int i = 0; i < sdx_pkg::MAX_RES - 1; i++) buf_nxt[i] = buf_r[i+1];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

@@ tb/soundex_text_encoder_test.sv @@
// Self-checking testbench for soundex_text_encoder: random and directed text in,
// per-word Soundex codes predicted and compared result by result.
// Depends on sdx_pkg and the encoder RTL.
module soundex_text_encoder_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TEXT_BYTES  = 160;
  localparam int MAX_PRINTED = 40;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SLOW, RX_MOSTLY} rx_mode_t;

  // Tracks word state of the text stream and holds the code characters due.
  class soundex_tracker;
    sdx_pkg::out_t chars_due[$];
    bit            in_word;
    bit            word_sent;
    logic [7:0]    lead;
    logic [2:0]    last_digit;
    int unsigned   n_digits;
    logic [2:0]    digits [sdx_pkg::DIGITS];
    // digit per letter A..Z
    string         digit_map = "01230120022455012623010202";

    function new();
      clear_text();
    endfunction

    function void clear_word();
      in_word = 0;
      lead = '0;
      last_digit = '0;
      n_digits = 0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    function void clear_text();
      clear_word();
      word_sent = 0;
    endfunction

    function logic [2:0] digit_of(logic [7:0] u);
      byte unsigned m;
      m = digit_map[u - sdx_pkg::CH_UP_A];
      return 3'(m - sdx_pkg::CH_ZERO);
    endfunction

    function void push_char(logic [7:0] ch, bit v);
      sdx_pkg::out_t r;
      r.code_char = ch;
      r.char_valid = v;
      r.output_end = 1'b0;
      chars_due.push_back(r);
    endfunction

    function void encode_byte(sdx_pkg::in_t req);
      logic [7:0]    c;
      logic [7:0]    u;
      logic [2:0]    d;
      bit            is_letter;
      int            first_new;
      sdx_pkg::out_t tail;
      c = req.text_char;
      u = '0;
      is_letter = 0;
      first_new = chars_due.size();
      if (c >= sdx_pkg::CH_UP_A && c <= sdx_pkg::CH_UP_Z) begin
        is_letter = 1;
        u = c;
      end else if (c >= sdx_pkg::CH_LO_A && c <= sdx_pkg::CH_LO_Z) begin
        is_letter = 1;
        u = c - sdx_pkg::CASE_GAP;
      end
      if (is_letter) begin
        d = digit_of(u);
        if (!in_word) begin
          // first letter's digit starts the run
          in_word = 1;
          lead = u;
          last_digit = d;
          n_digits = 0;
        end else if (u == sdx_pkg::CH_UP_H || u == sdx_pkg::CH_UP_W) begin
          // run carries across H and W
        end else if (d == 0) begin
          last_digit = '0;
        end else if (d != last_digit) begin
          if (n_digits < sdx_pkg::DIGITS) begin
            digits[n_digits] = d;
            n_digits++;
          end
          last_digit = d;
        end
      end
      if ((c == sdx_pkg::CH_SPACE || req.text_end) && in_word) begin
        if (word_sent) push_char(sdx_pkg::CH_SPACE, 1'b1);
        push_char(lead, 1'b1);
        for (int i = 0; i < sdx_pkg::DIGITS; i++)
          push_char(i < n_digits ? sdx_pkg::CH_ZERO + 8'(digits[i]) : sdx_pkg::CH_ZERO,
                    1'b1);
        word_sent = 1;
        clear_word();
      end
      if (req.text_end) begin
        if (chars_due.size() == first_new) push_char('0, 1'b0);
        tail = chars_due.pop_back();
        tail.output_end = 1'b1;
        chars_due.push_back(tail);
        clear_text();
      end
    endfunction

    // empty string when the result matches the oldest one due
    function string match_code(sdx_pkg::out_t got);
      sdx_pkg::out_t want;
      string         msg;
      if (chars_due.size() == 0)
        return $sformatf("unexpected result code_char=%h char_valid=%b output_end=%b",
                         got.code_char, got.char_valid, got.output_end);
      want = chars_due.pop_front();
      msg = "";
      if (got.code_char !== want.code_char)
        msg = {msg, $sformatf(" code_char %h/%h", got.code_char, want.code_char)};
      if (got.char_valid !== want.char_valid)
        msg = {msg, $sformatf(" char_valid %b/%b", got.char_valid, want.char_valid)};
      if (got.output_end !== want.output_end)
        msg = {msg, $sformatf(" output_end %b/%b", got.output_end, want.output_end)};
      if (msg != "") msg = {"result mismatch (got/want):", msg};
      return msg;
    endfunction

    function int pending();
      return chars_due.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  sdx_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  sdx_pkg::out_t out_data;

  soundex_text_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  soundex_tracker book;
  int             errors = 0;
  int             cycle = 0;
  int             burst_left = 0;
  int             text_bytes = 0;
  int             rx_left = 0;
  rx_mode_t       rx_mode = RX_ALWAYS;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR cycle %0d: %s", cycle, msg);
  endtask

  // receiver: stall pattern is redrawn at random whenever rx_left runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SLOW:   out_ready <= (cycle % 4 == 0);
      default:   out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      msg = book.match_code(out_data);
      if (msg != "") report_mismatch(msg);
    end
  end

  function automatic bit is_text_byte(logic [7:0] c);
    return c == sdx_pkg::CH_SPACE ||
           (c >= sdx_pkg::CH_UP_A && c <= sdx_pkg::CH_UP_Z) ||
           (c >= sdx_pkg::CH_LO_A && c <= sdx_pkg::CH_LO_Z);
  endfunction

  function automatic logic [7:0] rand_letter();
    string      runs = "BFPVCSHWAEY";
    logic [7:0] u;
    if ($urandom_range(0, 2) == 0) u = runs[$urandom_range(0, runs.len() - 1)];
    else u = sdx_pkg::CH_UP_A + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) u = u + sdx_pkg::CASE_GAP;
    return u;
  endfunction

  function automatic logic [7:0] rand_noise();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_text_byte(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_byte(logic [7:0] c, bit e);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = $urandom_range(20, 40);
      end else begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= {c, e};
    do @(posedge clk); while (!in_ready);
    book.encode_byte({c, e});
    burst_left--;
    if (is_text_byte(c) || e) text_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit end_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], end_last && i == s.len() - 1);
  endtask

  initial begin
    int n_words;
    int len;
    book = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // text with no word at all: bare end marker
    send_byte(8'h00, 1'b1);
    // Y counts as a vowel, repeated digits, first letter starts a run, H skipped
    send_text("Tymczak Pfh", 1'b1);
    // high bytes before and after a word's letters, W keeps a run, extra digits dropped,
    // text closed by a non-letter after a finished word
    send_byte(8'h80, 1'b0);
    send_text("BcwCdlmr", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("  ", 1'b0);
    send_byte(8'h01, 1'b1);

    while (text_bytes < TEXT_BYTES) begin
      n_words = $urandom_range(0, 4);
      for (int w = 0; w < n_words; w++) begin
        if (w > 0 || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(sdx_pkg::CH_SPACE, 1'b0);
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) send_byte(rand_noise(), 1'b0);
          send_byte(rand_letter(), 1'b0);
        end
      end
      case ($urandom_range(0, 2))
        0:       send_byte(rand_letter(), 1'b1);
        1:       send_byte(sdx_pkg::CH_SPACE, 1'b1);
        default: send_byte(rand_noise(), 1'b1);
      endcase
    end
    in_valid <= 1'b0;

    while (book.pending() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
